// ===== rtl/core/sle_pkg.sv =====
`default_nettype none
package sle_pkg;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_INSERT = 3'd1,
    OP_DELETE = 3'd2,
    OP_GET    = 3'd3,
    OP_LOCATE = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_GET,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] read_value;
    logic        [7:0]  found_position;
    logic        [7:0]  list_length;
  } result_t;

endpackage
`default_nettype wire

// ===== rtl/core/sle_store.sv =====
`default_nettype none
module sle_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic                  clk,
  input  wire logic                  we,
  input  wire logic [AW-1:0]         waddr,
  input  wire logic signed [31:0]    wdata,
  input  wire logic                  re,
  input  wire logic [AW-1:0]         raddr,
  output logic signed [31:0]         rdata
);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== rtl/core/sle_ctrl.sv =====
`default_nettype none
module sle_ctrl #(
  parameter int CAPACITY = 128
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [2:0]              in_operation,
  input  wire logic [7:0]              in_position,
  input  wire logic signed [31:0]      in_value,
  output logic                         res_valid,
  output sle_pkg::result_t             res,
  input  wire logic                    res_take
);
  import sle_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = ((CW > 8) ? CW : 8) + 1;
  localparam logic [CW-1:0] CAP_CW = CW'(CAPACITY);

  state_t             state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic               ins_r, ins_nxt;      // 1 insert, 0 delete while shifting
  logic [AW-1:0]      idx_r, idx_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CW-1:0]      rem_r, rem_nxt;
  logic               pend_r, pend_nxt;
  logic [AW-1:0]      pend_addr_r, pend_addr_nxt;
  result_t            res_r, res_nxt;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic signed [31:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic signed [31:0] mem_rdata;

  logic [PW-1:0]      pos_w;
  logic [PW-1:0]      count_w;
  logic               accept;

  assign pos_w    = PW'(in_position);
  assign count_w  = PW'(count_r);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  sle_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ins_r       <= ins_nxt;
    idx_r       <= idx_nxt;
    val_r       <= val_nxt;
    ptr_r       <= ptr_nxt;
    rem_r       <= rem_nxt;
    pend_addr_r <= pend_addr_nxt;
    res_r       <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ins_nxt       = ins_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ptr_nxt       = ptr_r;
    rem_nxt       = rem_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    res_nxt       = res_r;
    mem_we        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = ptr_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          res_nxt   = '0;
          pend_nxt  = 1'b0;
          val_nxt   = in_value;
          idx_nxt   = AW'(pos_w - PW'(1));
          state_nxt = ST_RESP;
          case (op_t'(in_operation))
            OP_CLEAR: begin
              count_nxt  = '0;
              res_nxt.ok = 1'b1;
            end
            OP_INSERT: begin
              if (in_position != 8'd0 && pos_w <= count_w + PW'(1) && count_r < CAP_CW) begin
                ins_nxt   = 1'b1;
                rem_nxt   = CW'(count_w - (pos_w - PW'(1)));
                ptr_nxt   = AW'(count_w - PW'(1));
                state_nxt = ST_SHIFT;
              end
            end
            OP_DELETE: begin
              if (in_position != 8'd0 && pos_w <= count_w) begin
                ins_nxt   = 1'b0;
                rem_nxt   = CW'(count_w - pos_w);
                ptr_nxt   = AW'(pos_w);
                state_nxt = ST_SHIFT;
              end
            end
            OP_GET: begin
              if (in_position != 8'd0 && pos_w <= count_w) begin
                mem_re    = 1'b1;
                mem_raddr = AW'(pos_w - PW'(1));
                state_nxt = ST_GET;
              end
            end
            OP_LOCATE: begin
              rem_nxt   = count_r;
              ptr_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            default: begin
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // one entry moves per cycle: read source now, write its destination next cycle
        mem_we = pend_r;
        if (rem_r != '0) begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ins_r ? ptr_r + AW'(1) : ptr_r - AW'(1);
          ptr_nxt       = ins_r ? ptr_r - AW'(1) : ptr_r + AW'(1);
          rem_nxt       = rem_r - CW'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            if (ins_r) begin
              mem_we    = 1'b1;
              mem_waddr = idx_r;
              mem_wdata = val_r;
              count_nxt = count_r + CW'(1);
            end else begin
              count_nxt = count_r - CW'(1);
            end
            res_nxt.ok = 1'b1;
            state_nxt  = ST_RESP;
          end
        end
      end

      ST_GET: begin
        res_nxt.ok         = 1'b1;
        res_nxt.read_value = mem_rdata;
        state_nxt          = ST_RESP;
      end

      ST_SCAN: begin
        // compare the entry read last cycle while fetching the next one
        if (pend_r && mem_rdata == val_r) begin
          pend_nxt               = 1'b0;
          res_nxt.ok             = 1'b1;
          res_nxt.found_position = 8'(PW'(pend_addr_r) + PW'(1));
          state_nxt              = ST_RESP;
        end else if (rem_r != '0) begin
          mem_re        = 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r;
          ptr_nxt       = ptr_r + AW'(1);
          rem_nxt       = rem_r - CW'(1);
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = ST_RESP;
        end
      end

      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (state_r != ST_RESP) begin
      res_nxt.list_length = 8'(PW'(count_nxt));
    end
  end

  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CW)
    else $error("list length above capacity");

  a_write_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_SHIFT)
    else $error("store written outside a shift");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted item did not start");

  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == ST_SHIFT || state_r == ST_SCAN))
    else $error("pending read outside shift or scan");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/sequential_list_engine_core.sv =====
`default_nettype none
// Clear, rejected and unknown items go straight to the result state; get waits on one store
//   read; locate scans until the first hit or the end of the list; insert and delete shift
//   the entries that lie behind the position.
// Throughput: one item at a time; in_stall is high until the result moves to the output register
//   and the next item can go in the cycle after that. Reset clears length, sequencer and
//   out_valid, not the list.
module sequential_list_engine_core #(
  parameter int CAPACITY = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         in_operation,
  input  wire logic [7:0]         in_position,
  input  wire logic signed [31:0] in_value,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_ok,
  output logic signed [31:0]      out_read_value,
  output logic [7:0]              out_found_position,
  output logic [7:0]              out_list_length
);
  import sle_pkg::*;

  logic    res_valid;
  result_t res;
  logic    res_take;

  // output register: a finished item waits here while the sequencer takes the next one
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  sle_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_operation(in_operation),
    .in_position (in_position),
    .in_value    (in_value),
    .res_valid   (res_valid),
    .res         (res),
    .res_take    (res_take)
  );

  // output register is free when empty or being drained this cycle
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_take) begin
      out_valid_nxt = res_valid;
      if (res_valid) begin
        out_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_ok             = out_r.ok;
  assign out_read_value     = out_r.read_value;
  assign out_found_position = out_r.found_position;
  assign out_list_length    = out_r.list_length;

endmodule
`default_nettype wire

// ===== sim/list_checker.sv =====
`timescale 1ns / 100ps
module list_checker #(
  parameter int DEPTH = 128
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [2:0]         in_operation,
  input  wire logic [7:0]         in_position,
  input  wire logic signed [31:0] in_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic               out_ok,
  input  wire logic signed [31:0] out_read_value,
  input  wire logic [7:0]         out_found_position,
  input  wire logic [7:0]         out_list_length,
  output int unsigned             mismatches,
  output int unsigned             outstanding,
  output int unsigned             compared
);
  import sle_pkg::*;

  logic signed [31:0] shadow_list [DEPTH];
  int unsigned        shadow_len;
  result_t            awaited_results [$];

  // Applies one list operation to the shadow copy and returns the result it gives.
  function automatic result_t apply_list_op(logic [2:0] op, logic [7:0] pos,
                                            logic signed [31:0] val);
    result_t res;
    int      p;
    int      idx;
    res = '0;
    p   = pos;
    case (op)
      OP_CLEAR: begin
        shadow_len = 0;
        res.ok     = 1'b1;
      end
      OP_INSERT: begin
        if (p >= 1 && p <= shadow_len + 1 && shadow_len < DEPTH) begin
          for (idx = shadow_len; idx > p - 1; idx--)
            shadow_list[idx] = shadow_list[idx - 1];
          shadow_list[p - 1] = val;
          shadow_len++;
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (p >= 1 && p <= shadow_len) begin
          for (idx = p - 1; idx + 1 < shadow_len; idx++)
            shadow_list[idx] = shadow_list[idx + 1];
          shadow_len--;
          res.ok = 1'b1;
        end
      end
      OP_GET: begin
        if (p >= 1 && p <= shadow_len) begin
          res.read_value = shadow_list[p - 1];
          res.ok         = 1'b1;
        end
      end
      OP_LOCATE: begin
        for (idx = 0; idx < shadow_len; idx++) begin
          if (shadow_list[idx] == val) begin
            res.found_position = 8'(idx + 1);
            res.ok             = 1'b1;
            break;
          end
        end
      end
      default: ;  // reserved codes leave everything alone
    endcase
    res.list_length = 8'(shadow_len);
    return res;
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      awaited_results.delete();
      shadow_len = 0;
      mismatches = 0;
      compared   = 0;
    end else begin
      // results first: one taken at this edge belongs to an earlier item
      if (out_valid && !out_stall) begin
        got.ok             = out_ok;
        got.read_value     = out_read_value;
        got.found_position = out_found_position;
        got.list_length    = out_list_length;
        if (awaited_results.size() == 0) begin
          if (mismatches < 10)
            $display("%t list_checker: result with no item pending:", $time,
                     " ok=%0b rd=%0d fp=%0d len=%0d",
                     got.ok, got.read_value, got.found_position, got.list_length);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          compared++;
          if (got.ok !== want.ok || got.read_value !== want.read_value ||
              got.found_position !== want.found_position ||
              got.list_length !== want.list_length) begin
            if (mismatches < 10)
              $display("%t list_checker: expected ok=%0b rd=%0d fp=%0d len=%0d,",
                       $time, want.ok, want.read_value, want.found_position,
                       want.list_length, " got ok=%0b rd=%0d fp=%0d len=%0d",
                       got.ok, got.read_value, got.found_position, got.list_length);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        awaited_results.push_back(apply_list_op(in_operation, in_position, in_value));
    end
    outstanding = awaited_results.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import sle_pkg::*;

  localparam int LIST_DEPTH  = 128;
  localparam int ITEM_TARGET = 1250;
  // codes past locate are reserved; the block must answer them without touching the list
  localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
  localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

  logic               clk;
  logic               rst_n        = 1'b0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [2:0]         in_operation = OP_CLEAR;
  logic [7:0]         in_position  = '0;
  logic signed [31:0] in_value     = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               out_ok;
  logic signed [31:0] out_read_value;
  logic [7:0]         out_found_position;
  logic [7:0]         out_list_length;

  int unsigned        mismatch_total;
  int unsigned        pending_results;
  int unsigned        results_compared;

  sequential_list_engine_core #(
    .CAPACITY(LIST_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_found_position(out_found_position),
    .out_list_length   (out_list_length)
  );

  list_checker #(
    .DEPTH(LIST_DEPTH)
  ) u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_read_value    (out_read_value),
    .out_found_position(out_found_position),
    .out_list_length   (out_list_length),
    .mismatches        (mismatch_total),
    .outstanding       (pending_results),
    .compared          (results_compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legal run (every item a full 128-entry shift or scan,
  // worst gaps and stalls) is well under a third of this.
  initial begin
    #10_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: stalls follow an 8-bit mask, stepped by a free-running phase and
  // redrawn after each random stretch. About a quarter of the stretches never
  // stall; bit 0 is always clear so no mask blocks the channel for good.
  // ---------------------------------------------------------------------------
  logic [7:0]  stall_mask  = '0;
  logic [2:0]  stall_phase = '0;
  int unsigned stall_span  = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_span <= $urandom_range(16, 300);
      stall_mask <= ($urandom_range(0, 3) == 0) ? 8'h00 : (8'($urandom) & 8'hFE);
    end else begin
      stall_span <= stall_span - 1;
    end
    stall_phase <= stall_phase + 3'd1;
    out_stall   <= rst_n && stall_mask[stall_phase];
  end

  // ---------------------------------------------------------------------------
  // Sender state. len_now follows the list length only to aim positions at
  // the interesting spots; checking is left entirely to the checker.
  // ---------------------------------------------------------------------------
  int unsigned        len_now        = 0;
  int unsigned        peak_len       = 0;
  int unsigned        items_known    = 0;   // items with a defined operation
  int unsigned        items_reserved = 0;   // items with a reserved code
  int unsigned        burst_left     = 0;
  int unsigned        op_tally [8];
  logic signed [31:0] value_pool [8];

  // Drive one item and hold it until the block takes it. Mid-burst it returns at the
  // accepting edge with in_valid high, so a back-to-back item overwrites the payload at
  // that same edge; at a burst's end it drops in_valid and waits a random gap first.
  task automatic send_item(input logic [2:0] op, input logic [7:0] pos,
                           input logic signed [31:0] val);
    in_valid     <= 1'b1;
    in_operation <= op;
    in_position  <= pos;
    in_value     <= val;
    do @(posedge clk); while (in_stall);

    op_tally[op]++;
    if (op <= OP_LOCATE) items_known++;
    else items_reserved++;
    case (op)
      OP_CLEAR:  len_now = 0;
      OP_INSERT: if (pos >= 1 && pos <= len_now + 1 && len_now < LIST_DEPTH) len_now++;
      OP_DELETE: if (pos >= 1 && pos <= len_now) len_now--;
      default: ;
    endcase
    if (len_now > peak_len) peak_len = len_now;

    // bursts of random length; now and then a long run with no gaps at all
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
    end
  endtask

  // Mostly values from a small pool so locates hit and duplicates appear.
  function automatic logic signed [31:0] pick_value();
    return ($urandom_range(0, 99) < 65) ? value_pool[$urandom_range(0, 7)]
                                        : $signed($urandom);
  endfunction

  // Fill the list to capacity at random positions, knock on the full list,
  // read and search the long list, then delete some and start over.
  task automatic fill_and_drain();
    logic signed [31:0] probe;
    send_item(OP_CLEAR, 8'($urandom), $signed($urandom));
    while (len_now < LIST_DEPTH)
      send_item(OP_INSERT, 8'($urandom_range(1, len_now + 1)), pick_value());
    send_item(OP_INSERT, 8'(LIST_DEPTH + 1), pick_value());   // append when full
    send_item(OP_INSERT, 8'd1, pick_value());                 // front when full
    send_item(OP_GET, 8'(LIST_DEPTH), '0);
    send_item(OP_GET, 8'(LIST_DEPTH + 1), '0);
    repeat (4) send_item(OP_LOCATE, '0, pick_value());
    probe = $signed($urandom);
    send_item(OP_LOCATE, '0, probe);                          // almost surely a full-length miss
    send_item(OP_DELETE, 8'(LIST_DEPTH), '0);                 // last entry
    send_item(OP_DELETE, 8'd1, '0);
    repeat (12) send_item(OP_DELETE, 8'($urandom_range(1, len_now)), '0);
    send_item(OP_CLEAR, '0, '0);
  endtask

  initial begin
    logic [2:0]  op;
    int unsigned roll;
    int unsigned pick;
    bit          refilled;

    refilled = 1'b0;
    foreach (op_tally[k]) op_tally[k] = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: empty list, bounds, extremes, duplicates, reserved codes
    send_item(OP_GET,    8'd1, '0);              // get on empty list
    send_item(OP_DELETE, 8'd0, '0);              // delete position zero
    send_item(OP_LOCATE, 8'd0, '0);              // locate in empty list
    send_item(OP_INSERT, 8'd0, 32'sd5);          // insert position zero
    send_item(OP_INSERT, 8'd2, 32'sd5);          // past length+1
    send_item(OP_INSERT, 8'd1, 32'sh7FFF_FFFF);
    send_item(OP_INSERT, 8'd2, 32'sh8000_0000);  // append
    send_item(OP_INSERT, 8'd1, -32'sd1);         // front, shifts both up
    send_item(OP_INSERT, 8'd3, 32'sd0);          // middle: -1, max, 0, min
    send_item(OP_GET,    8'd255, '0);
    send_item(OP_GET,    8'd4, '0);
    send_item(OP_GET,    8'd1, '0);
    send_item(OP_LOCATE, 8'd255, 32'sh8000_0000);
    send_item(OP_LOCATE, 8'd0, 32'sd12345);      // miss over whole list
    send_item(OP_INSERT, 8'd5, -32'sd1);         // duplicate at the tail
    send_item(OP_LOCATE, 8'd0, -32'sd1);         // first occurrence wins
    send_item(OP_DELETE, 8'd6, '0);              // one past length
    send_item(OP_DELETE, 8'd1, '0);
    send_item(OP_DELETE, 8'd4, '0);              // last entry
    for (op = OP_RESERVED_FIRST; op <= OP_RESERVED_LAST && op >= OP_RESERVED_FIRST; op++)
      send_item(op, 8'd255, $signed($urandom));
    send_item(OP_CLEAR,  8'd0, '0);
    send_item(OP_GET,    8'd1, '0);              // stale entries must stay hidden
    send_item(OP_LOCATE, 8'd0, 32'sh7FFF_FFFF);

    // ---- random: well-formed traffic, boundary hits, some pure noise
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7FFF_FFFF;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int k = 4; k < 8; k++) value_pool[k] = $signed($urandom);

    fill_and_drain();
    while (items_known < ITEM_TARGET) begin
      if (!refilled && items_known >= ITEM_TARGET / 2) begin
        fill_and_drain();
        refilled = 1'b1;
      end
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        // legal positions; clears keep most lists short so shifts stay cheap
        pick = $urandom_range(0, 99);
        if (pick < 36)
          send_item(OP_INSERT, 8'($urandom_range(1, len_now + 1)), pick_value());
        else if (pick < 60)
          send_item(OP_DELETE, 8'((len_now == 0) ? 1 : $urandom_range(1, len_now)), '0);
        else if (pick < 78)
          send_item(OP_GET, 8'((len_now == 0) ? 1 : $urandom_range(1, len_now)),
                    $signed($urandom));
        else if (pick < 97)
          send_item(OP_LOCATE, 8'($urandom), pick_value());
        else
          send_item(OP_CLEAR, 8'($urandom), $signed($urandom));
      end else if (roll < 92) begin
        // zero, the last entry, one past it
        pick = $urandom_range(0, 2);
        send_item(3'($urandom_range(OP_INSERT, OP_GET)),
                  8'((pick == 0) ? 0 : (pick == 1) ? len_now : len_now + 1),
                  pick_value());
      end else begin
        send_item(3'($urandom_range(OP_CLEAR, OP_RESERVED_LAST)), 8'($urandom),
                  $signed($urandom));
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching for stray results
    while (pending_results != 0) @(posedge clk);
    repeat (150) @(posedge clk);

    $display("tb_top: %0d items: clear %0d, insert %0d, delete %0d,",
             items_known + items_reserved, op_tally[OP_CLEAR], op_tally[OP_INSERT],
             op_tally[OP_DELETE], " get %0d, locate %0d, reserved %0d",
             op_tally[OP_GET], op_tally[OP_LOCATE], items_reserved);
    $display("tb_top: %0d results compared, list length peaked at %0d of %0d",
             results_compared, peak_len, LIST_DEPTH);
    if (mismatch_total == 0 && pending_results == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/sle_pkg.sv
rtl/core/sle_store.sv
rtl/core/sle_ctrl.sv
rtl/core/sequential_list_engine_core.sv
sim/list_checker.sv
sim/tb_top.sv
